// File: rtl/core/cfnm_pkg.sv
// ----------------------------------------------------------------------------
// cfnm_pkg
// Shared types and constants for the codebook fully connected neuron MAC.
// ----------------------------------------------------------------------------
package cfnm_pkg;

    // Fixed-point format: Q8.8 data, Q16.16 products, 48-bit accumulator
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = DATA_WIDTH / 2;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int ACC_WIDTH  = 48;
    localparam int SUM_WIDTH  = ACC_WIDTH + 1;

    // Field widths
    localparam int INDEX_WIDTH = 10;
    localparam int LABEL_WIDTH = 8;
    localparam int LBITS_WIDTH = 4;

    // Input item kinds (carried on s_tuser)
    typedef enum logic [1:0] {
        MODE_CB_WRITE   = 2'd0,
        MODE_BIAS_WRITE = 2'd1,
        MODE_MAC        = 2'd2,
        MODE_UNUSED     = 2'd3
    } mode_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_RELU_ENABLE = 2'd0;
    localparam logic [1:0] CFG_BIAS_ENABLE = 2'd1;
    localparam logic [1:0] CFG_LABEL_BITS  = 2'd2;

    // Term travelling from the input stage to the multiplier
    typedef struct packed {
        logic                          mac;
        logic                          last;
        logic [INDEX_WIDTH-1:0]        nid;
        logic signed [DATA_WIDTH-1:0]  act;
        logic                          bias_ok;
    } term_t;

    // Finished dot product travelling to the output stage
    typedef struct packed {
        logic signed [ACC_WIDTH-1:0]   sum;
        logic [INDEX_WIDTH-1:0]        nid;
        logic signed [DATA_WIDTH-1:0]  bias;
        logic                          bias_ok;
    } dot_t;

endpackage

// File: rtl/core/cfnm_ram.sv
// ----------------------------------------------------------------------------
// cfnm_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module cfnm_ram #(
    parameter int WIDTH      = 16,
    parameter int DEPTH      = 256,
    parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [ADDR_WIDTH-1:0] waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  re,
    input  logic [ADDR_WIDTH-1:0] raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read; read data holds while re is low
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/cfnm_mac.sv
// ----------------------------------------------------------------------------
// cfnm_mac
// Multiply stage and accumulate stage; hands finished dot products onward.
// ----------------------------------------------------------------------------
module cfnm_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  cfnm_pkg::term_t                     in_term,
    input  logic [cfnm_pkg::DATA_WIDTH-1:0]     cb_data,
    input  logic [cfnm_pkg::DATA_WIDTH-1:0]     bias_rd,
    output logic                                out_valid,
    input  logic                                out_ready,
    output cfnm_pkg::dot_t                      out_dot
);

    // Multiply stage
    logic                                       mul_valid_reg;
    cfnm_pkg::term_t                            mul_term_reg;
    logic signed [cfnm_pkg::PROD_WIDTH-1:0]     mul_prod_reg;
    logic signed [cfnm_pkg::DATA_WIDTH-1:0]     mul_bias_reg;

    // Accumulate stage
    logic                                       acc_valid_reg;
    logic                                       acc_valid_next;
    cfnm_pkg::dot_t                             acc_dot_reg;
    logic signed [cfnm_pkg::ACC_WIDTH-1:0]      acc_reg;
    logic signed [cfnm_pkg::ACC_WIDTH-1:0]      acc_next;
    logic signed [cfnm_pkg::ACC_WIDTH-1:0]      acc_sum;

    logic mul_ready;
    logic acc_ready;
    logic mul_move;

    assign acc_ready = !acc_valid_reg || out_ready;
    assign mul_ready = !mul_valid_reg || acc_ready;
    assign mul_move  = mul_valid_reg && acc_ready;
    assign in_ready  = mul_ready;

    // Q8.8 x Q8.8 product, exact
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (mul_ready) begin
            mul_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_ready && in_valid) begin
            mul_term_reg <= in_term;
            mul_prod_reg <= in_term.act * $signed(cb_data);
            mul_bias_reg <= $signed(bias_rd);
        end
    end

    // Accumulator wraps modulo 2^48; cleared after the last term
    assign acc_sum = acc_reg + {{(cfnm_pkg::ACC_WIDTH - cfnm_pkg::PROD_WIDTH)
                                 {mul_prod_reg[cfnm_pkg::PROD_WIDTH-1]}}, mul_prod_reg};

    always_comb begin
        acc_next       = acc_reg;
        acc_valid_next = acc_valid_reg;
        if (mul_move && mul_term_reg.mac) begin
            acc_next = mul_term_reg.last ? '0 : acc_sum;
        end
        if (acc_ready) begin
            acc_valid_next = mul_valid_reg && mul_term_reg.mac && mul_term_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            acc_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            acc_valid_reg <= acc_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_move && mul_term_reg.mac && mul_term_reg.last) begin
            acc_dot_reg.sum     <= acc_sum;
            acc_dot_reg.nid     <= mul_term_reg.nid;
            acc_dot_reg.bias    <= mul_bias_reg;
            acc_dot_reg.bias_ok <= mul_term_reg.bias_ok;
        end
    end

    assign out_valid = acc_valid_reg;
    assign out_dot   = acc_dot_reg;

endmodule

// File: rtl/core/cfnm_post.sv
// ----------------------------------------------------------------------------
// cfnm_post
// Bias add and ReLU stage, then rescale and saturate into the result register.
// ----------------------------------------------------------------------------
module cfnm_post (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                relu_enable,
    input  logic                                bias_enable,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  cfnm_pkg::dot_t                      in_dot,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [cfnm_pkg::DATA_WIDTH-1:0]     m_value,
    output logic [cfnm_pkg::INDEX_WIDTH-1:0]    m_id,
    output logic                                m_sat
);

    localparam int QW = cfnm_pkg::SUM_WIDTH - cfnm_pkg::FRAC_BITS;
    localparam int DW = cfnm_pkg::DATA_WIDTH;

    logic                                       bias_valid_reg;
    logic signed [cfnm_pkg::SUM_WIDTH-1:0]      bias_sum_reg;
    logic [cfnm_pkg::INDEX_WIDTH-1:0]           bias_nid_reg;

    logic                                       out_valid_reg;
    logic [DW-1:0]                              out_value_reg;
    logic [cfnm_pkg::INDEX_WIDTH-1:0]           out_id_reg;
    logic                                       out_sat_reg;

    logic                                       out_ready;
    logic                                       bias_ready;
    logic signed [cfnm_pkg::SUM_WIDTH-1:0]      bias_term;
    logic signed [cfnm_pkg::SUM_WIDTH-1:0]      biased;
    logic signed [cfnm_pkg::SUM_WIDTH-1:0]      rectified;
    logic [QW-1:0]                              q;
    logic                                       sat_hi;
    logic                                       sat_lo;

    assign out_ready  = !out_valid_reg || m_ready;
    assign bias_ready = !bias_valid_reg || out_ready;
    assign in_ready   = bias_ready;

    // Bias scaled by 2^F, added exactly; ReLU clamps negatives
    always_comb begin
        bias_term = '0;
        if (bias_enable && in_dot.bias_ok) begin
            bias_term = {{(cfnm_pkg::SUM_WIDTH - DW - cfnm_pkg::FRAC_BITS){in_dot.bias[DW-1]}},
                         in_dot.bias, {cfnm_pkg::FRAC_BITS{1'b0}}};
        end
        biased    = {in_dot.sum[cfnm_pkg::ACC_WIDTH-1], in_dot.sum} + bias_term;
        rectified = (relu_enable && biased[cfnm_pkg::SUM_WIDTH-1]) ? '0 : biased;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_valid_reg <= 1'b0;
        end else if (bias_ready) begin
            bias_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (bias_ready && in_valid) begin
            bias_sum_reg <= rectified;
            bias_nid_reg <= in_dot.nid;
        end
    end

    // Floor shift by F is the upper bits; clip to the Q8.8 range
    assign q      = bias_sum_reg[cfnm_pkg::SUM_WIDTH-1:cfnm_pkg::FRAC_BITS];
    assign sat_hi = !q[QW-1] && (|q[QW-2:DW-1]);
    assign sat_lo = q[QW-1] && !(&q[QW-2:DW-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= bias_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && bias_valid_reg) begin
            if (sat_hi) begin
                out_value_reg <= {1'b0, {(DW-1){1'b1}}};
            end else if (sat_lo) begin
                out_value_reg <= {1'b1, {(DW-1){1'b0}}};
            end else begin
                out_value_reg <= q[DW-1:0];
            end
            out_sat_reg <= sat_hi || sat_lo;
            out_id_reg  <= bias_nid_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_value = out_value_reg;
    assign m_id    = out_id_reg;
    assign m_sat   = out_sat_reg;

endmodule

// File: rtl/core/codebook_fc_neuron_mac_top.sv
// ----------------------------------------------------------------------------
// codebook_fc_neuron_mac_top
// One fully connected neuron with codebook-labelled weights and stored biases.
// ----------------------------------------------------------------------------
// Path: input, multiply, accumulate, bias and output registers to m_tvalid.
// Throughput: one transaction per cycle unless m_tready stalls, set by the
// 48-bit accumulator add and the one read port of each table RAM.
// Reset: clears the accumulator, pipeline valids and configuration
// (relu off, bias off, label_bits 8). Codebook and bias RAMs are not
// cleared and must be written before they are read.
// ----------------------------------------------------------------------------
module codebook_fc_neuron_mac_top #(
    parameter int MAX_NEURONS    = 1024,
    parameter int MAX_LABEL_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: table_index[9:0], table_value[25:10], activation[41:26],
    //        weight_label[49:42], neuron_index[59:50], zero pad[63:60]
    input  logic [63:0] s_tdata,
    // tuser: mode[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: neuron_value[15:0], neuron_id[25:16], zero pad[31:26]
    output logic [31:0] m_tdata,
    // tuser: saturated[0]
    output logic        m_tuser
);

    localparam int DW         = cfnm_pkg::DATA_WIDTH;
    localparam int IW         = cfnm_pkg::INDEX_WIDTH;
    localparam int CB_DEPTH   = 1 << MAX_LABEL_BITS;
    localparam int CB_AW      = MAX_LABEL_BITS;
    localparam int BIAS_DEPTH = (MAX_NEURONS < (1 << IW)) ? MAX_NEURONS : (1 << IW);
    localparam int BIAS_AW    = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;

    // Unpacked input fields
    logic [IW-1:0]                   table_index;
    logic [DW-1:0]                   table_value;
    logic [DW-1:0]                   activation;
    logic [cfnm_pkg::LABEL_WIDTH-1:0] weight_label;
    logic [IW-1:0]                   neuron_index;
    cfnm_pkg::mode_t                 mode;

    assign table_index  = s_tdata[9:0];
    assign table_value  = s_tdata[25:10];
    assign activation   = s_tdata[41:26];
    assign weight_label = s_tdata[49:42];
    assign neuron_index = s_tdata[59:50];
    assign mode         = cfnm_pkg::mode_t'(s_tuser);

    // Configuration registers
    logic                            relu_enable_reg;
    logic                            bias_enable_reg;
    logic [cfnm_pkg::LBITS_WIDTH-1:0] label_bits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relu_enable_reg <= 1'b0;
            bias_enable_reg <= 1'b0;
            label_bits_reg  <= 4'd8;
        end else if (cfg_we) begin
            case (cfg_index)
                cfnm_pkg::CFG_RELU_ENABLE: relu_enable_reg <= cfg_data[0];
                cfnm_pkg::CFG_BIAS_ENABLE: bias_enable_reg <= cfg_data[0];
                cfnm_pkg::CFG_LABEL_BITS:  label_bits_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage handshake
    logic            in_valid_reg;
    cfnm_pkg::term_t in_term_reg;
    cfnm_pkg::term_t term_next;
    logic            mac_ready;
    logic            in_ready;
    logic            accept;

    assign in_ready = !in_valid_reg || mac_ready;
    assign s_tready = in_ready;
    assign accept   = s_tvalid && in_ready;

    // Label width clamped to 1..MAX_LABEL_BITS, then masked
    logic [cfnm_pkg::LBITS_WIDTH-1:0] lbits_eff;
    logic [CB_AW-1:0]                 label_mask;
    logic [CB_AW-1:0]                 cb_raddr;

    always_comb begin
        lbits_eff = label_bits_reg;
        if (label_bits_reg == '0) begin
            lbits_eff = 4'd1;
        end else if (label_bits_reg > cfnm_pkg::LBITS_WIDTH'(MAX_LABEL_BITS)) begin
            lbits_eff = cfnm_pkg::LBITS_WIDTH'(MAX_LABEL_BITS);
        end
        for (int i = 0; i < CB_AW; i++) begin
            label_mask[i] = (cfnm_pkg::LBITS_WIDTH'(i) < lbits_eff);
        end
    end

    assign cb_raddr = weight_label[CB_AW-1:0] & label_mask;

    // Table writes, ignored beyond the table depth
    logic cb_we;
    logic bias_we;

    assign cb_we   = accept && (mode == cfnm_pkg::MODE_CB_WRITE)
                     && ({22'd0, table_index} < CB_DEPTH);
    assign bias_we = accept && (mode == cfnm_pkg::MODE_BIAS_WRITE)
                     && ({22'd0, table_index} < BIAS_DEPTH);

    logic [DW-1:0] cb_rdata;
    logic [DW-1:0] bias_rdata;

    cfnm_ram #(
        .WIDTH      (DW),
        .DEPTH      (CB_DEPTH),
        .ADDR_WIDTH (CB_AW)
    ) u_cb_ram (
        .aclk  (aclk),
        .we    (cb_we),
        .waddr (table_index[CB_AW-1:0]),
        .wdata (table_value),
        .re    (accept),
        .raddr (cb_raddr),
        .rdata (cb_rdata)
    );

    cfnm_ram #(
        .WIDTH      (DW),
        .DEPTH      (BIAS_DEPTH),
        .ADDR_WIDTH (BIAS_AW)
    ) u_bias_ram (
        .aclk  (aclk),
        .we    (bias_we),
        .waddr (table_index[BIAS_AW-1:0]),
        .wdata (table_value),
        .re    (accept),
        .raddr (neuron_index[BIAS_AW-1:0]),
        .rdata (bias_rdata)
    );

    // Input register, aligned with the RAM read data
    always_comb begin
        term_next.mac     = (mode == cfnm_pkg::MODE_MAC);
        term_next.last    = s_tlast;
        term_next.nid     = neuron_index;
        term_next.act     = $signed(activation);
        term_next.bias_ok = ({22'd0, neuron_index} < BIAS_DEPTH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_term_reg <= term_next;
        end
    end

    // Multiply and accumulate
    logic           dot_valid;
    logic           dot_ready;
    cfnm_pkg::dot_t dot;

    cfnm_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (mac_ready),
        .in_term   (in_term_reg),
        .cb_data   (cb_rdata),
        .bias_rd   (bias_rdata),
        .out_valid (dot_valid),
        .out_ready (dot_ready),
        .out_dot   (dot)
    );

    // Bias, ReLU, rescale, saturate
    logic [DW-1:0] neuron_value;
    logic [IW-1:0] neuron_id;
    logic          saturated;

    cfnm_post u_post (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .relu_enable (relu_enable_reg),
        .bias_enable (bias_enable_reg),
        .in_valid    (dot_valid),
        .in_ready    (dot_ready),
        .in_dot      (dot),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_value     (neuron_value),
        .m_id        (neuron_id),
        .m_sat       (saturated)
    );

    assign m_tdata = {6'd0, neuron_id, neuron_value};
    assign m_tuser = saturated;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the codebook fully connected neuron MAC.
// Streams table writes and multiply-accumulate terms into the block, predicts
// every neuron result from its own copy of the tables, accumulator and
// configuration, and checks each result transaction field by field. Covers
// directed corner values, several register settings, four idling phases and
// a long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;

    localparam int ITEMS_PER_BLOCK = 150;  // useful items per register setting
    localparam int DRAIN_CYCLES    = 12;   // margin after the last result is taken
    localparam int HOLD_CYCLES     = 400;  // long receiver hold-off
    localparam int WATCHDOG_LIMIT  = 3000; // quiet cycles before giving up
    localparam int Q_MAX           = 2 ** (cfnm_pkg::DATA_WIDTH - 1) - 1;
    localparam int Q_MIN           = -(2 ** (cfnm_pkg::DATA_WIDTH - 1));

    // One input transaction, unpacked into its fields
    typedef struct packed {
        cfnm_pkg::mode_t    mode;
        logic [9:0]         tix;
        logic signed [15:0] tval;
        logic signed [15:0] act;
        logic [7:0]         label;
        logic [9:0]         nid;
        logic               last;
    } term_item_t;

    // One neuron result
    typedef struct packed {
        logic [15:0] value;
        logic [9:0]  id;
        logic        saturated;
    } neuron_result_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [3:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    // Predicted block state
    logic signed [15:0] cb_mem [256];
    bit                 cb_written [256];
    logic signed [15:0] bias_mem [1024];
    bit                 bias_written [1024];
    logic [9:0]         bias_ids [$];
    logic signed [47:0] acc_q   = '0;
    logic               relu_on = 1'b0;
    logic               bias_on = 1'b0;
    logic [3:0]         lbits   = 4'd8;

    neuron_result_t pending_neurons [$];
    neuron_result_t want;

    // Idling and hold-off control
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_ack       = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    // Run statistics
    int err_count       = 0;
    int useful_items    = 0;
    int mac_terms       = 0;
    int table_writes    = 0;
    int results_checked = 0;
    int results_clipped = 0;
    int cfg_settings    = 0;

    codebook_fc_neuron_mac_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Effective label mask; a width of 0 acts as 1, above 8 acts as 8
    function automatic logic [7:0] label_mask();
        int w;
        w = (lbits == 0) ? 1 : ((lbits > 8) ? 8 : int'(lbits));
        return 8'((1 << w) - 1);
    endfunction

    // Advance the predicted state by one accepted transaction
    function automatic void apply_to_neuron_model(term_item_t it);
        logic [7:0]         lab;
        logic signed [63:0] prod;
        logic signed [63:0] sum;
        logic signed [63:0] q;
        neuron_result_t     res;
        case (it.mode)
            cfnm_pkg::MODE_CB_WRITE: begin
                // out-of-range codebook address is dropped
                if (it.tix < 256) begin
                    cb_mem[it.tix[7:0]]     = it.tval;
                    cb_written[it.tix[7:0]] = 1'b1;
                end
            end
            cfnm_pkg::MODE_BIAS_WRITE: begin
                if (!bias_written[it.tix])
                    bias_ids.push_back(it.tix);
                bias_written[it.tix] = 1'b1;
                bias_mem[it.tix]     = it.tval;
            end
            cfnm_pkg::MODE_MAC: begin
                lab   = it.label & label_mask();
                prod  = it.act * cb_mem[lab];
                acc_q = acc_q + prod[47:0];
                if (it.last) begin
                    sum   = acc_q;
                    acc_q = '0;
                    if (bias_on)
                        sum = sum + (bias_mem[it.nid] <<< cfnm_pkg::FRAC_BITS);
                    if (relu_on && sum < 0)
                        sum = 0;
                    // arithmetic shift floors towards minus infinity
                    q = sum >>> cfnm_pkg::FRAC_BITS;
                    res.saturated = 1'b0;
                    if (q > Q_MAX) begin
                        q = Q_MAX;
                        res.saturated = 1'b1;
                    end else if (q < Q_MIN) begin
                        q = Q_MIN;
                        res.saturated = 1'b1;
                    end
                    res.value = q[15:0];
                    res.id    = it.nid;
                    pending_neurons.push_back(res);
                end
            end
            default: ;  // unused mode leaves everything alone
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Item construction
    // ------------------------------------------------------------------------

    // Q8.8 value: full range, small, medium or an extreme
    function automatic logic signed [15:0] rand_q88();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(1023)) - 512);
            2: return 16'(int'($urandom_range(8191)) - 4096);
            default: begin
                case ($urandom_range(4))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    3: return 16'sh0001;
                    default: return 16'shFFFF;
                endcase
            end
        endcase
    endfunction

    // Write or unused item; the fields it does not use are random
    function automatic term_item_t table_write(cfnm_pkg::mode_t m, int unsigned idx,
                                               logic signed [15:0] val);
        term_item_t it;
        it.mode  = m;
        it.tix   = 10'(idx);
        it.tval  = val;
        it.act   = 16'($urandom);
        it.label = 8'($urandom);
        it.nid   = 10'($urandom);
        it.last  = 1'($urandom);
        return it;
    endfunction

    function automatic term_item_t mac_term(logic signed [15:0] act, logic [7:0] label,
                                            logic [9:0] nid, logic last);
        term_item_t it;
        it.mode  = cfnm_pkg::MODE_MAC;
        it.tix   = 10'($urandom);
        it.tval  = 16'($urandom);
        it.act   = act;
        it.label = label;
        it.nid   = nid;
        it.last  = last;
        return it;
    endfunction

    // Random label whose masked value addresses a loaded codebook entry
    function automatic logic [7:0] pick_label();
        logic [7:0] msk;
        logic [7:0] raw;
        int         e;
        msk = label_mask();
        for (int k = 0; k < 32; k++) begin
            raw = 8'($urandom);
            if (cb_written[raw & msk])
                return raw;
        end
        // fall back on a loaded entry that fits the mask (entry 0 always does)
        do e = $urandom_range(255); while (!cb_written[e] || (8'(e) & ~msk) != 0);
        return (8'($urandom) & ~msk) | 8'(e);
    endfunction

    function automatic logic [9:0] pick_bias_id();
        return bias_ids[$urandom_range(bias_ids.size() - 1)];
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one transaction and wait for it to be taken
    task automatic send_term(term_item_t it);
        int gap;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tlast  <= it.last;
        s_tdata  <= {4'b0, it.nid, it.label, it.act, it.tval, it.tix};
        do @(posedge aclk); while (!s_tready);
        apply_to_neuron_model(it);
        if (it.mode == cfnm_pkg::MODE_MAC) begin
            mac_terms++;
            useful_items++;
        end else if (it.mode == cfnm_pkg::MODE_BIAS_WRITE ||
                     (it.mode == cfnm_pkg::MODE_CB_WRITE && it.tix < 256)) begin
            table_writes++;
            useful_items++;
        end
    endtask

    // Stop sending, let every expected result out, then let the pipe empty
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_neurons.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            cfnm_pkg::CFG_RELU_ENABLE: relu_on = val[0];
            cfnm_pkg::CFG_BIAS_ENABLE: bias_on = val[0];
            cfnm_pkg::CFG_LABEL_BITS:  lbits   = val;
            default: ;
        endcase
    endtask

    // Registers change only with the block idle
    task automatic set_config(logic relu, logic bias, logic [3:0] lb);
        wait_results_drained();
        write_reg(cfnm_pkg::CFG_RELU_ENABLE, {3'b0, relu});
        write_reg(cfnm_pkg::CFG_BIAS_ENABLE, {3'b0, bias});
        write_reg(cfnm_pkg::CFG_LABEL_BITS, lb);
        cfg_we <= 1'b0;
        cfg_settings++;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // A dot product with random content, sometimes preceded by table updates
    // and sometimes interrupted by stray writes or unused-mode items
    task automatic send_random_neuron();
        int   n_terms;
        int   m;
        logic last;
        if ($urandom_range(99) < 25)
            send_term(table_write(cfnm_pkg::MODE_CB_WRITE, $urandom_range(255), rand_q88()));
        if ($urandom_range(99) < 15)
            send_term(table_write(cfnm_pkg::MODE_BIAS_WRITE, $urandom_range(1023),
                                  rand_q88()));
        n_terms = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        for (int t = 0; t < n_terms; t++) begin
            if ($urandom_range(99) < 8) begin
                m = $urandom_range(2);
                send_term(table_write((m == 0) ? cfnm_pkg::MODE_CB_WRITE :
                                      (m == 1) ? cfnm_pkg::MODE_BIAS_WRITE :
                                                 cfnm_pkg::MODE_UNUSED,
                                      $urandom_range(1023), 16'($urandom)));
            end
            last = (t == n_terms - 1);
            send_term(mac_term(rand_q88(), pick_label(),
                               last ? pick_bias_id() : 10'($urandom), last));
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_neurons.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result, expected none, actual value %h id %0d sat %b",
                         $time, m_tdata[15:0], m_tdata[25:16], m_tuser);
            end else begin
                want = pending_neurons.pop_front();
                results_checked++;
                if (want.saturated)
                    results_clipped++;
                if (m_tdata[15:0] !== want.value) begin
                    err_count++;
                    $display("%0t: neuron_value mismatch, expected %h actual %h",
                             $time, want.value, m_tdata[15:0]);
                end
                if (m_tdata[25:16] !== want.id) begin
                    err_count++;
                    $display("%0t: neuron_id mismatch, expected %0d actual %0d",
                             $time, want.id, m_tdata[25:16]);
                end
                if (m_tuser !== want.saturated) begin
                    err_count++;
                    $display("%0t: saturated mismatch, expected %b actual %b",
                             $time, want.saturated, m_tuser);
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Table loads at the extremes, dropped codebook addresses, unused mode
    task automatic test_table_writes();
        send_term(table_write(cfnm_pkg::MODE_CB_WRITE, 0, 16'sh0100));
        send_term(table_write(cfnm_pkg::MODE_CB_WRITE, 255, 16'sh7FFF));
        send_term(table_write(cfnm_pkg::MODE_CB_WRITE, 128, 16'sh8000));
        send_term(table_write(cfnm_pkg::MODE_CB_WRITE, 1, 16'shFFFF));
        send_term(table_write(cfnm_pkg::MODE_CB_WRITE, 256, 16'sh1234));
        send_term(table_write(cfnm_pkg::MODE_CB_WRITE, 1023, 16'shFFFF));
        send_term(table_write(cfnm_pkg::MODE_BIAS_WRITE, 0, 16'sh0080));
        send_term(table_write(cfnm_pkg::MODE_BIAS_WRITE, 1023, 16'sh8000));
        send_term(table_write(cfnm_pkg::MODE_UNUSED, 1023, 16'sh7FFF));
    endtask

    // Exact results, rounding towards minus infinity, clipping both ways
    task automatic test_mac_arithmetic();
        send_term(mac_term(16'sh0100, 8'd0, 10'd0, 1'b1));
        send_term(mac_term(16'sh8000, 8'd128, 10'd1023, 1'b1));
        send_term(mac_term(16'sh7FFF, 8'd128, 10'd5, 1'b0));
        send_term(mac_term(16'sh7FFF, 8'd255, 10'd1023, 1'b1));
        send_term(mac_term(16'shFFFF, 8'd0, 10'd7, 1'b0));
        send_term(mac_term(16'shFFFF, 8'd1, 10'd0, 1'b1));
        send_term(mac_term(16'sh7FFF, 8'd128, 10'd0, 1'b1));
    endtask

    // Bias, ReLU and the label width including its out-of-range settings
    task automatic test_config_registers();
        set_config(1'b0, 1'b1, 4'd8);
        send_term(mac_term(16'sh0000, 8'd0, 10'd0, 1'b1));
        send_term(mac_term(16'sh8000, 8'd0, 10'd1023, 1'b1));
        set_config(1'b1, 1'b1, 4'd8);
        send_term(mac_term(16'sh8000, 8'd0, 10'd1023, 1'b1));
        set_config(1'b0, 1'b0, 4'd1);
        send_term(mac_term(16'sh0100, 8'hFF, 10'd0, 1'b1));
        set_config(1'b0, 1'b0, 4'd0);
        send_term(mac_term(16'sh0100, 8'hFE, 10'd0, 1'b1));
        set_config(1'b0, 1'b0, 4'd15);
        send_term(mac_term(16'sh0100, 8'hFF, 10'd0, 1'b1));
    endtask

    // Random dot products under one idling pattern and three settings
    task automatic test_random_traffic(int phase, int send_pct, int recv_pct);
        int start;
        set_idling(send_pct, recv_pct);
        for (int blk = 0; blk < 3; blk++) begin
            if (blk == 0) begin
                case (phase)
                    0: set_config(1'b0, 1'b0, 4'd8);
                    1: set_config(1'b1, 1'b1, 4'd1);
                    2: set_config(1'b1, 1'b0, 4'd15);
                    default: set_config(1'b0, 1'b1, 4'd0);
                endcase
            end else begin
                set_config(1'($urandom), 1'($urandom), 4'($urandom));
            end
            start = useful_items;
            while (useful_items - start < ITEMS_PER_BLOCK)
                send_random_neuron();
        end
    endtask

    // Hold the output off for a long stretch while single-term neurons keep
    // coming, so the block fills and stalls its input
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_req <= hold_req + 1;
        for (int k = 0; k < 80; k++)
            send_term(mac_term(rand_q88(), pick_label(), pick_bias_id(), 1'b1));
        // then pause until every outstanding result has been taken
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_table_writes();
        test_mac_arithmetic();
        test_config_registers();
        test_random_traffic(0, 0, 0);
        test_random_traffic(1, 69, 0);
        test_random_traffic(2, 0, 69);
        test_random_traffic(3, 25, 25);
        test_backpressure();

        set_idling(0, 0);
        wait_results_drained();

        $display("Run covered %0d useful transactions: %0d MAC terms, %0d table writes",
                 useful_items, mac_terms, table_writes);
        $display("%0d neuron results checked (%0d clipped) over %0d register settings",
                 results_checked, results_clipped, cfg_settings);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
